// ===== design/ets_pkg.sv =====
package ets_pkg;

	localparam int unsigned MAX_ENTRIES = 65536;
	localparam int unsigned AW = $clog2(MAX_ENTRIES);
	localparam int unsigned DW = 16;
	localparam int unsigned IW = 16;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNBUILT = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	localparam logic CMD_BUILD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		RD_QRY = 2'd0,
		RD_I   = 2'd1,
		RD_J   = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    cap_item;
		logic    cnt_clr;
		logic    cnt_inc;
		logic    i_init;
		logic    i_inc;
		logic    x_init;
		logic    p_step;
		logic    x_step;
		logic    j_init;
		logic    j_step;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    q_ld;
		logic    wr_init;
		logic    wr_upd;
		logic    out_ld;
	} ets_ctrl_t;

	typedef struct packed {
		logic is_query;
		logic lim_lt2;
		logic cnt_last;
		logic i_last;
		logic i_is2;
		logic is_prime;
		logic j_last;
	} ets_stat_t;

endpackage

// ===== design/ets_dpath.sv =====
module ets_dpath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ets_pkg::ets_ctrl_t      ctrl,
	output ets_pkg::ets_stat_t      stat,
	input  logic                    cfg_wr,
	input  logic [15:0]             cfg_data,
	input  logic                    command,
	input  logic [ets_pkg::IW-1:0]  query_index,
	output logic [ets_pkg::DW-1:0]  totient_value,
	output logic [1:0]              status
);
	import ets_pkg::*;

	logic [15:0]     table_limit_q;
	logic            built_q;
	logic [AW-1:0]   built_lim_q;
	logic            cmd_q;
	logic [IW-1:0]   qi_q;
	logic [AW-1:0]   lim_q;
	logic [AW-1:0]   lim_eff;
	logic [AW-1:0]   cnt_q;
	logic [AW-1:0]   i_q;
	logic [AW-1:0]   j_q;
	logic [DW-1:0]   x_q;
	logic [DW-1:0]   prod_q;
	logic [DW-1:0]   quot_q;
	logic [DW-1:0]   rdata_q;
	logic [DW-1:0]   value_q;
	logic [1:0]      status_q;
	logic [DW-1:0]   tbl_mem [MAX_ENTRIES];
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic [DW-1:0]   wr_data;
	logic            wr_en;
	logic [DW-1:0]   mul_a;
	logic [DW-1:0]   mul_b;
	logic [2*DW-1:0] mul_full;
	logic [DW-1:0]   mul_p;
	logic [DW-1:0]   i_dw;
	logic            q_err;
	logic [1:0]      q_status;

	assign i_dw = DW'(i_q);

	always_comb begin
		if (32'(table_limit_q) > 32'(MAX_ENTRIES - 1)) begin
			lim_eff = AW'(MAX_ENTRIES - 1);
		end else begin
			lim_eff = AW'(table_limit_q);
		end
	end

	// one shared multiplier, modulo 2^16 throughout
	always_comb begin
		mul_a = quot_q;
		mul_b = i_dw - DW'(1);
		if (ctrl.p_step) begin
			mul_a = i_dw;
			mul_b = x_q;
		end else if (ctrl.x_step) begin
			mul_a = x_q;
			mul_b = DW'(2) - prod_q;
		end else if (ctrl.q_ld) begin
			mul_a = rdata_q;
			mul_b = x_q;
		end
	end

	assign mul_full = mul_a * mul_b;
	assign mul_p    = mul_full[DW-1:0];

	always_comb begin
		case (ctrl.rd_sel)
			RD_QRY:  rd_addr = AW'(qi_q);
			RD_I:    rd_addr = i_q;
			RD_J:    rd_addr = j_q;
			default: rd_addr = i_q;
		endcase
	end

	assign wr_en   = ctrl.wr_init | ctrl.wr_upd;
	assign wr_addr = ctrl.wr_init ? cnt_q : j_q;
	assign wr_data = ctrl.wr_init ? DW'(cnt_q) : mul_p;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rdata_q <= tbl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_limit_q <= 16'hFFFF;
			built_q       <= 1'b0;
		end else begin
			if (cfg_wr) begin
				table_limit_q <= cfg_data;
			end
			if (ctrl.out_ld && cmd_q == CMD_BUILD) begin
				built_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cap_item) begin
			cmd_q <= command;
			qi_q  <= query_index;
			lim_q <= lim_eff;
		end
		if (ctrl.out_ld && cmd_q == CMD_BUILD) begin
			built_lim_q <= lim_q;
		end
		if (ctrl.cnt_clr) begin
			cnt_q <= '0;
		end else if (ctrl.cnt_inc) begin
			cnt_q <= cnt_q + AW'(1);
		end
		if (ctrl.i_init) begin
			i_q <= AW'(2);
		end else if (ctrl.i_inc) begin
			i_q <= i_q + AW'(1);
		end
		if (ctrl.j_init) begin
			j_q <= i_q;
		end else if (ctrl.j_step) begin
			j_q <= j_q + i_q;
		end
		// odd prime: newton steps for its inverse mod 2^16, seeded by the prime itself
		if (ctrl.x_init) begin
			x_q <= i_dw;
		end else if (ctrl.x_step) begin
			x_q <= mul_p;
		end
		if (ctrl.p_step) begin
			prod_q <= mul_p;
		end
		// entry is an exact multiple of the prime here
		if (ctrl.q_ld) begin
			quot_q <= ctrl.x_step ? mul_p : (stat.i_is2 ? (rdata_q >> 1) : mul_p);
		end
		if (ctrl.out_ld) begin
			value_q  <= (cmd_q == CMD_QUERY && !q_err) ? rdata_q : '0;
			status_q <= (cmd_q == CMD_QUERY) ? q_status : ST_OK;
		end
	end

	always_comb begin
		if (!built_q) begin
			q_status = ST_UNBUILT;
		end else if (32'(qi_q) > 32'(built_lim_q)) begin
			q_status = ST_RANGE;
		end else begin
			q_status = ST_OK;
		end
	end

	assign q_err = (q_status != ST_OK);

	assign stat.is_query = (cmd_q == CMD_QUERY);
	assign stat.lim_lt2  = (lim_q < AW'(2));
	assign stat.cnt_last = (cnt_q == lim_q);
	assign stat.i_last   = (i_q == lim_q);
	assign stat.i_is2    = (i_q == AW'(2));
	assign stat.is_prime = (rdata_q == i_dw);
	assign stat.j_last   = ({1'b0, j_q} + {1'b0, i_q}) > {1'b0, lim_q};

	assign totient_value = value_q;
	assign status        = status_q;

endmodule

// ===== design/ets_ctrl.sv =====
module ets_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ets_pkg::ets_stat_t  stat,
	output ets_pkg::ets_ctrl_t  ctrl
);
	import ets_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_DEC   = 11'b000_0000_0010,
		S_QOUT  = 11'b000_0000_0100,
		S_INIT  = 11'b000_0000_1000,
		S_CHK   = 11'b000_0001_0000,
		S_CHKW  = 11'b000_0010_0000,
		S_INVP  = 11'b000_0100_0000,
		S_INVX  = 11'b000_1000_0000,
		S_RD    = 11'b001_0000_0000,
		S_MUL   = 11'b010_0000_0000,
		S_WR    = 11'b100_0000_0000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic       out_valid_q;
	logic [1:0] itc_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctrl    = '0;
		ctrl.rd_sel = RD_QRY;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.cap_item = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (stat.is_query) begin
					ctrl.rd_en  = 1'b1;
					ctrl.rd_sel = RD_QRY;
					state_d = S_QOUT;
				end else begin
					ctrl.cnt_clr = 1'b1;
					state_d = S_INIT;
				end
			end
			S_QOUT: begin
				if (out_free) begin
					ctrl.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_INIT: begin
				ctrl.wr_init = 1'b1;
				ctrl.cnt_inc = 1'b1;
				if (stat.cnt_last) begin
					ctrl.i_init = 1'b1;
					state_d = stat.lim_lt2 ? S_QOUT : S_CHK;
				end
			end
			S_CHK: begin
				ctrl.rd_en  = 1'b1;
				ctrl.rd_sel = RD_I;
				state_d = S_CHKW;
			end
			S_CHKW: begin
				if (stat.is_prime) begin
					ctrl.j_init = 1'b1;
					ctrl.x_init = 1'b1;
					state_d = stat.i_is2 ? S_RD : S_INVP;
				end else if (stat.i_last) begin
					state_d = S_QOUT;
				end else begin
					ctrl.i_inc = 1'b1;
					state_d = S_CHK;
				end
			end
			S_INVP: begin
				ctrl.p_step = 1'b1;
				state_d = S_INVX;
			end
			S_INVX: begin
				ctrl.x_step = 1'b1;
				state_d = (itc_q == 2'd2) ? S_RD : S_INVP;
			end
			S_RD: begin
				ctrl.rd_en  = 1'b1;
				ctrl.rd_sel = RD_J;
				state_d = S_MUL;
			end
			S_MUL: begin
				ctrl.q_ld = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				ctrl.wr_upd = 1'b1;
				if (!stat.j_last) begin
					ctrl.j_step = 1'b1;
					state_d = S_RD;
				end else if (stat.i_last) begin
					state_d = S_QOUT;
				end else begin
					ctrl.i_inc = 1'b1;
					state_d = S_CHK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			itc_q       <= 2'd0;
		end else begin
			state_q <= state_d;
			if (ctrl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.x_init) begin
				itc_q <= 2'd0;
			end else if (ctrl.x_step) begin
				itc_q <= itc_q + 2'd1;
			end
		end
	end

endmodule

// ===== design/euler_totient_sieve.sv =====
// query: index registered, table read, then result loaded once the output is free
// build: seeds entries 0..lim, tests indices from 2 for primality, inverts odd primes
//   by Newton steps and rewrites each multiple by read, multiply, write (one write port)
// result waits in an output register while the next item is accepted
// reset: asynchronous, clears control, table_limit to 65535, table marked unbuilt
module euler_totient_sieve (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   command,
	input  logic [ets_pkg::IW-1:0] query_index,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ets_pkg::DW-1:0] totient_value,
	output logic [1:0]             status,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [15:0]            table_limit
);
	import ets_pkg::*;

	ets_ctrl_t ctrl;
	ets_stat_t stat;

	assign cfg_ready = 1'b1;

	ets_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	ets_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.cfg_wr        (cfg_valid && cfg_ready),
		.cfg_data      (table_limit),
		.command       (command),
		.query_index   (query_index),
		.totient_value (totient_value),
		.status        (status)
	);

	// one item at a time: no second transfer straight after the first
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while busy");

	// result register is only loaded when empty or being drained
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_ld |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

	// seeding and update writes never coincide
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.wr_init && ctrl.wr_upd))
		else $error("two table writes in one cycle");

	// status code three is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_UNBUILT || status == ST_RANGE))
		else $error("invalid status code");

endmodule

// ===== sim/euler_totient_sieve_tb.sv =====
`timescale 1ns / 1ps

module euler_totient_sieve_tb;
	import ets_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 8_000_000;
	localparam int unsigned PHASES = 9;
	localparam int unsigned PHASE_ITEMS = 215;
	localparam int unsigned LAST_PHASE_ITEMS = 150;

	typedef struct packed {
		logic [DW-1:0] value;
		logic [1:0]    status;
	} phi_res_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_LIMIT
	} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic          cmd;
		logic [IW-1:0] arg;
		logic          fixed;
		phi_res_t      res;
	} row_t;

	// builds, error codes and lookups of indices 0 to 2 are typed in, other lookups go through the sieve
	localparam int unsigned DIR_ROWS = 25;
	localparam row_t DIR_TAB [DIR_ROWS] = '{
		'{ROW_ITEM,  CMD_QUERY, 16'd0,     1'b1, '{16'd0, ST_UNBUILT}},
		'{ROW_ITEM,  CMD_QUERY, 16'hffff,  1'b1, '{16'd0, ST_UNBUILT}},
		'{ROW_LIMIT, CMD_BUILD, 16'd0,     1'b0, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_BUILD, 16'd0,     1'b1, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd0,     1'b1, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd1,     1'b1, '{16'd0, ST_RANGE}},
		'{ROW_LIMIT, CMD_BUILD, 16'd1,     1'b0, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_BUILD, 16'hffff,  1'b1, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd1,     1'b1, '{16'd1, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd2,     1'b1, '{16'd0, ST_RANGE}},
		'{ROW_LIMIT, CMD_BUILD, 16'd2,     1'b0, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_BUILD, 16'h5a5a,  1'b1, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd2,     1'b1, '{16'd1, ST_OK}},
		'{ROW_LIMIT, CMD_BUILD, 16'd120,   1'b0, '{16'd0, ST_OK}},
		// new limit is not live until the next build
		'{ROW_ITEM,  CMD_QUERY, 16'd3,     1'b1, '{16'd0, ST_RANGE}},
		'{ROW_ITEM,  CMD_BUILD, 16'd0,     1'b1, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd97,    1'b0, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd120,   1'b0, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd64,    1'b0, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd121,   1'b1, '{16'd0, ST_RANGE}},
		'{ROW_ITEM,  CMD_QUERY, 16'hffff,  1'b1, '{16'd0, ST_RANGE}},
		'{ROW_ITEM,  CMD_QUERY, 16'h8000,  1'b1, '{16'd0, ST_RANGE}},
		'{ROW_ITEM,  CMD_QUERY, 16'd0,     1'b1, '{16'd0, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd1,     1'b1, '{16'd1, ST_OK}},
		'{ROW_ITEM,  CMD_QUERY, 16'd105,   1'b0, '{16'd0, ST_OK}}
	};

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic          command;
	logic [IW-1:0] query_index;
	logic          out_valid;
	logic          out_ready;
	logic [DW-1:0] totient_value;
	logic [1:0]    status;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [15:0]   table_limit;

	// sieve copy of the table and its control state
	logic [DW-1:0] phi_model [0:MAX_ENTRIES-1];
	logic          phi_built;
	int unsigned   phi_lim;
	logic [15:0]   limit_reg;

	phi_res_t      phi_pending [$];
	phi_res_t      phi_head;
	int unsigned   errors = 0;
	int unsigned   cycles = 0;
	int unsigned   tx_burst = 0;
	int unsigned   rx_burst = 0;

	euler_totient_sieve uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.query_index   (query_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.totient_value (totient_value),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.table_limit   (table_limit)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void sieve_fill(input int unsigned lim);
		int unsigned i;
		int unsigned j;
		for (i = 0; i <= lim; i++)
			phi_model[i] = 16'(i);
		for (i = 2; i <= lim; i++) begin
			if (phi_model[i] == 16'(i)) begin
				for (j = i; j <= lim; j += i)
					phi_model[j] = 16'((phi_model[j] / i) * (i - 1));
			end
		end
	endfunction

	function automatic phi_res_t totient_predict(input logic cmd, input logic [IW-1:0] idx);
		phi_res_t    r;
		int unsigned lim;
		r.value = '0;
		r.status = ST_OK;
		if (cmd == CMD_BUILD) begin
			lim = (limit_reg > MAX_ENTRIES - 1) ? MAX_ENTRIES - 1 : limit_reg;
			sieve_fill(lim);
			phi_lim = lim;
			phi_built = 1'b1;
		end else if (!phi_built) begin
			r.status = ST_UNBUILT;
		end else if (idx > phi_lim) begin
			r.status = ST_RANGE;
		end else begin
			r.value = phi_model[idx];
		end
		return r;
	endfunction

	// idle cycles before the next transfer, with runs of back-to-back ones
	function automatic int unsigned draw_wait(inout int unsigned burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			burst = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		errors++;
		if (errors <= 50)
			$display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
	endtask

	task automatic send_item(input logic cmd, input logic [IW-1:0] idx, input logic fixed,
			input phi_res_t fixed_res);
		int unsigned gap;
		phi_res_t    r;
		gap = draw_wait(tx_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		query_index <= idx;
		do @(posedge clk); while (!in_ready);
		r = totient_predict(cmd, idx);
		phi_pending.push_back(fixed ? fixed_res : r);
	endtask

	// only once the block has drained
	task automatic write_limit(input logic [15:0] lim);
		in_valid <= 1'b0;
		while (phi_pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		table_limit <= lim;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_reg = lim;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (phi_pending.size() == 0) begin
				report("result with nothing pending", totient_value, 0);
			end else begin
				phi_head = phi_pending.pop_front();
				if (totient_value !== phi_head.value)
					report("totient_value", totient_value, phi_head.value);
				if (status !== phi_head.status)
					report("status", status, phi_head.status);
			end
		end
	end

	initial begin
		int unsigned stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(rx_burst);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int unsigned ph;
		int unsigned k;
		int unsigned n;
		int unsigned pre;
		int unsigned r;
		int unsigned lim;
		int unsigned near_idx;
		logic        build_ok;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_QUERY;
		query_index <= '0;
		cfg_valid <= 1'b0;
		table_limit <= '0;
		phi_built = 1'b0;
		phi_lim = 0;
		limit_reg = 16'hffff;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_ROWS; k++) begin
			if (DIR_TAB[k].kind == ROW_LIMIT)
				write_limit(DIR_TAB[k].arg);
			else
				send_item(DIR_TAB[k].cmd, DIR_TAB[k].arg, DIR_TAB[k].fixed, DIR_TAB[k].res);
		end

		// small tables mostly; the last phase builds the full 16-bit range once
		for (ph = 0; ph < PHASES; ph++) begin
			build_ok = (ph != PHASES - 1);
			if (!build_ok) begin
				lim = 16'hffff;
				n = LAST_PHASE_ITEMS;
			end else begin
				r = $urandom_range(0, 9);
				if (r == 0)
					lim = $urandom_range(0, 1);
				else if (r == 1)
					lim = $urandom_range(201, 1500);
				else
					lim = $urandom_range(2, 200);
				n = PHASE_ITEMS;
			end
			write_limit(16'(lim));
			// in about a third of the phases, one to eight lookups against the old table before the rebuild
			pre = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
			for (k = 0; k < n; k++) begin
				r = $urandom_range(0, 99);
				if (k == pre) begin
					send_item(CMD_BUILD, 16'($urandom), 1'b0, '0);
				end else if (build_ok && r < 2) begin
					send_item(CMD_BUILD, 16'($urandom), 1'b0, '0);
				end else if (r < 80) begin
					send_item(CMD_QUERY, 16'($urandom_range(0, phi_lim)), 1'b0, '0);
				end else if (r < 90) begin
					near_idx = phi_lim + $urandom_range(0, 3);
					if (near_idx > 16'hffff)
						near_idx = 16'hffff;
					send_item(CMD_QUERY, 16'(near_idx), 1'b0, '0);
				end else begin
					send_item(CMD_QUERY, 16'($urandom), 1'b0, '0);
				end
			end
		end

		in_valid <= 1'b0;
		while (phi_pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && phi_pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
